@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the keypad lock RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define KCL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define KCL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/kcl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants of the keypad code lock
// ----------------------------------------------------------------------------
package kcl_pkg;

   // default code length and reset value of the attempt limit
   localparam int unsigned KCL_CODE_LENGTH  = 4;
   localparam logic [3:0]  KCL_ATTEMPTS_RST = 4'd3;

   // register index of the attempt limit
   localparam int unsigned REG_MAX_ATTEMPTS = 0;

   // result status codes
   typedef enum logic [3:0] {
      ST_IGNORED    = 4'd0,
      ST_OPEN       = 4'd1,
      ST_CHANGE     = 4'd2,
      ST_KEY        = 4'd3,
      ST_UNLOCKED   = 4'd4,
      ST_WRONG      = 4'd5,
      ST_ENTER_NEW  = 4'd6,
      ST_CHANGED    = 4'd7,
      ST_NOW_LOCKED = 4'd8,
      ST_LOCKED     = 4'd9
   } status_type;

   // one result beat
   typedef struct packed {
      status_type status;
      logic [1:0] key_value;
      logic [1:0] key_position;
      logic [3:0] attempts_left;
   } result_type;

endpackage

@@ hdl/kcl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_if
// Valid/ready channels of the keypad code lock: press events in, results out
// ----------------------------------------------------------------------------

// press event channel
interface kcl_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] buttons;

   modport source (output valid, output buttons, input ready);
   modport sink   (input valid, input buttons, output ready);
endinterface

// result channel
interface kcl_rsp_if
   import kcl_pkg::*;
   ;
   logic       valid;
   logic       ready;
   status_type status;
   logic [1:0] key_value;
   logic [1:0] key_position;
   logic [3:0] attempts_left;

   modport source (output valid, output status, output key_value,
                   output key_position, output attempts_left, input ready);
   modport sink   (input valid, input status, input key_value,
                   input key_position, input attempts_left, output ready);
endinterface

@@ hdl/kcl_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_csr
// APB register file holding the attempt limit
// ----------------------------------------------------------------------------
module kcl_csr
   import kcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [3:0]  max_attempts
);

   logic [3:0] max_attempts_ff;
   logic [3:0] max_attempts_in;
   logic       wr_en;

   // the only register sits at byte offset zero, low address bits are byte lanes
   assign wr_en = psel && penable && pwrite && (paddr[1:0] == 2'(REG_MAX_ATTEMPTS * 4));

   always_comb begin
      max_attempts_in = max_attempts_ff;
      if (wr_en) begin
         max_attempts_in = pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff <= KCL_ATTEMPTS_RST;
      end else begin
         max_attempts_ff <= max_attempts_in;
      end
   end

   assign pready       = 1'b1;
   assign prdata       = {28'd0, max_attempts_ff};
   assign max_attempts = max_attempts_ff;

endmodule

@@ hdl/kcl_lock_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_lock_fsm
// Lock state, code storage and the per-beat decision logic
// ----------------------------------------------------------------------------
module kcl_lock_fsm
   import kcl_pkg::*;
#(
   parameter int unsigned CODE_LENGTH = KCL_CODE_LENGTH
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [3:0] buttons,
   input  logic [3:0] max_attempts,
   output result_type result
);

   localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ENTRY  = 2'd1,
      PH_LOCKED = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      MODE_OPEN   = 2'd0,
      MODE_VERIFY = 2'd1,
      MODE_NEW    = 2'd2
   } mode_type;

   phase_type        phase_ff, phase_in;
   mode_type         mode_ff, mode_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [3:0]       attempts_ff, attempts_in;
   logic [1:0]       stored_ff  [CODE_LENGTH];
   logic [1:0]       stored_in  [CODE_LENGTH];
   logic [1:0]       entered_ff [CODE_LENGTH];
   logic [1:0]       entered_in [CODE_LENGTH];
   logic [1:0]       key_now;
   logic [CODE_LENGTH-1:0] eq;
   logic             match;

   // highest pressed button wins
   function automatic logic [1:0] top_key(input logic [3:0] mask);
      logic [1:0] k;
      if (mask[3])      k = 2'd3;
      else if (mask[2]) k = 2'd2;
      else if (mask[1]) k = 2'd1;
      else              k = 2'd0;
      return k;
   endfunction

   assign key_now = top_key(buttons);

   // entry-wise compare, entered view already carries this beat's key
   always_comb begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
         eq[i] = (((IDX_W'(i) == idx_ff) ? key_now : entered_ff[i]) == stored_ff[i]);
      end
   end
   assign match = &eq;

   // next state and result of the beat in the input register
   always_comb begin
      phase_in    = phase_ff;
      mode_in     = mode_ff;
      idx_in      = idx_ff;
      attempts_in = attempts_ff;
      stored_in   = stored_ff;
      entered_in  = entered_ff;
      result      = '{status: ST_IGNORED, key_value: 2'd0, key_position: 2'd0,
                      attempts_left: 4'd0};
      case (phase_ff)
         PH_LOCKED: begin
            result.status = ST_LOCKED;
         end
         PH_ENTRY: begin
            if (buttons != 4'd0) begin
               result.key_value    = key_now;
               result.key_position = 2'(idx_ff);
               result.status       = ST_KEY;
               if (mode_ff == MODE_NEW) stored_in[idx_ff] = key_now;
               else                     entered_in[idx_ff] = key_now;
               if (idx_ff != IDX_W'(CODE_LENGTH - 1)) begin
                  idx_in = idx_ff + IDX_W'(1);
               end else begin
                  idx_in = '0;
                  if (mode_ff == MODE_NEW) begin
                     mode_in       = MODE_OPEN;
                     phase_in      = PH_IDLE;
                     result.status = ST_CHANGED;
                  end else if (match) begin
                     attempts_in = max_attempts;
                     if (mode_ff == MODE_VERIFY) begin
                        mode_in       = MODE_NEW;
                        result.status = ST_ENTER_NEW;
                     end else begin
                        phase_in      = PH_IDLE;
                        result.status = ST_UNLOCKED;
                     end
                  end else begin
                     if (attempts_ff != 4'd0) attempts_in = attempts_ff - 4'd1;
                     mode_in = MODE_OPEN;
                     if (attempts_in == 4'd0) begin
                        phase_in      = PH_LOCKED;
                        result.status = ST_NOW_LOCKED;
                     end else begin
                        phase_in      = PH_IDLE;
                        result.status = ST_WRONG;
                     end
                  end
               end
            end
         end
         default: begin
            // idle: open entry has priority over code change
            if (buttons[3] && buttons[0]) begin
               phase_in      = PH_ENTRY;
               mode_in       = MODE_OPEN;
               idx_in        = '0;
               result.status = ST_OPEN;
            end else if (buttons[2] && buttons[1]) begin
               phase_in      = PH_ENTRY;
               mode_in       = MODE_VERIFY;
               idx_in        = '0;
               result.status = ST_CHANGE;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
      result.attempts_left = attempts_in;
   end

   // control state and stored code
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         mode_ff     <= MODE_OPEN;
         idx_ff      <= '0;
         attempts_ff <= KCL_ATTEMPTS_RST;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            stored_ff[i] <= 2'(i);
         end
      end else if (step) begin
         phase_ff    <= phase_in;
         mode_ff     <= mode_in;
         idx_ff      <= idx_in;
         attempts_ff <= attempts_in;
         stored_ff   <= stored_in;
      end
   end

   // entered code, written before it is ever compared
   always_ff @(posedge clock) begin
      if (step) begin
         entered_ff <= entered_in;
      end
   end

endmodule

@@ hdl/keypad_code_lock_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_unit
// Four-button combination lock driven by debounced press events
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one press event per beat (buttons mask, bit0 A .. bit3 D).
//   rsp_chan returns exactly one result beat per press event, in order:
//   status, key taken, its position in the code and attempts left.
//   The APB port holds max_attempts at offset 0; write it only while idle.
// Pipeline and throughput:
//   A beat is captured in the input register, decided against the lock state
//   once the result register is free and loaded into the result register. One
//   beat per cycle is sustained while rsp_chan.ready stays high.
// Stalls:
//   When rsp_chan.ready is low the result register holds; one more press event
//   is still taken into the input register, then req_chan.ready drops.
// Reset:
//   Synchronous reset empties both registers, returns to idle with the code
//   ABCD repeating, three attempts and max_attempts at three. No clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_code_lock_unit
   import kcl_pkg::*;
#(
   parameter int unsigned CODE_LENGTH = KCL_CODE_LENGTH
)(
   input  logic        clock,
   input  logic        reset,
   kcl_req_if.sink     req_chan,
   kcl_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic       in_vld_ff, in_vld_in;
   logic [3:0] in_buttons_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_res_ff;
   result_type res;
   logic       out_free;
   logic       step;
   logic [3:0] max_attempts;

   // register file
   kcl_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .max_attempts (max_attempts)
   );

   // lock state and decision
   kcl_lock_fsm #(.CODE_LENGTH(CODE_LENGTH)) u_fsm (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .buttons      (in_buttons_ff),
      .max_attempts (max_attempts),
      .result       (res)
   );

   // handshake between the input and result registers
   assign out_free       = !out_vld_ff || rsp_chan.ready;
   assign step           = in_vld_ff && out_free;
   assign req_chan.ready = !in_vld_ff || step;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_chan.ready) in_vld_in = req_chan.valid;
      out_vld_in = out_vld_ff;
      if (out_free) out_vld_in = step;
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) in_buttons_ff <= req_chan.buttons;
      if (step) out_res_ff <= res;
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.status        = out_res_ff.status;
   assign rsp_chan.key_value     = out_res_ff.key_value;
   assign rsp_chan.key_position  = out_res_ff.key_position;
   assign rsp_chan.attempts_left = out_res_ff.attempts_left;

   // a decided beat always lands in the result register
   `KCL_ASSERT_NXT(a_step_fills_out, clock, reset, step, out_vld_ff,
      "decided beat did not reach the result register")

   // a waiting beat in the input register is kept while the result stalls
   `KCL_ASSERT_NXT(a_in_holds, clock, reset, in_vld_ff && !out_free,
      in_vld_ff && $stable(in_buttons_ff), "input register lost a waiting beat")

   // an accepted beat is present in the input register next cycle
   `KCL_ASSERT_NXT(a_accept_lands, clock, reset, req_chan.valid && req_chan.ready,
      in_vld_ff, "accepted beat missing from input register")

   // no key reported unless a key was taken
   `KCL_ASSERT_IMP(a_no_stray_key, clock, reset,
      out_vld_ff && (out_res_ff.status == ST_IGNORED || out_res_ff.status == ST_OPEN ||
      out_res_ff.status == ST_CHANGE || out_res_ff.status == ST_LOCKED),
      out_res_ff.key_value == 2'd0 && out_res_ff.key_position == 2'd0,
      "key reported on a beat that took no key")

endmodule
